### hw/rtl/trd_pkg.sv
package trd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int INDEX_WIDTH  = 16;
  localparam int NUM_CHANNELS = 6;
  localparam int LEN_WIDTH    = 16;
  localparam int SEL_WIDTH    = 3;
  localparam int MODE_WIDTH   = 2;
  localparam int CFG_WIDTH    = 16;
  localparam int REG_IDX_WIDTH = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef sample_t [NUM_CHANNELS-1:0]      chan_arr_t;
  typedef logic [INDEX_WIDTH-1:0]          index_t;
  typedef logic [LEN_WIDTH-1:0]            len_t;
  typedef logic [SEL_WIDTH-1:0]            sel_t;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_ABOVE = 2'd0,
    MODE_BAND  = 2'd1,
    MODE_DUAL  = 2'd2
  } mode_t;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_COMPARE_MODE     = 3'd0,
    REG_CHANNEL_A_SELECT = 3'd1,
    REG_CHANNEL_B_SELECT = 3'd2,
    REG_THRESHOLD_A_LOW  = 3'd3,
    REG_THRESHOLD_A_HIGH = 3'd4,
    REG_THRESHOLD_B      = 3'd5,
    REG_MIN_RUN_LENGTH   = 3'd6,
    REG_REPORT_ALL       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0] compare_mode;
    sel_t                  channel_a_select;
    sel_t                  channel_b_select;
    sample_t               threshold_a_low;
    sample_t               threshold_a_high;
    sample_t               threshold_b;
    len_t                  min_run_length;
    logic                  report_all;
  } cfg_t;

  typedef struct packed {
    logic   run_found;
    index_t run_start_index;
    index_t run_end_index;
    logic   search_done;
    logic   none_found;
  } result_t;

  typedef struct packed {
    logic in_run;
    logic any_reported;
  } trk_status_t;

endpackage

### hw/rtl/threshold_run_detector.sv
// Timing: a transaction accepted at one edge is tested in the following cycle, and its result,
// if any, is registered when the input register advances, which an output stall can delay.
// Throughput: one sample per cycle, set by the single input register and result register;
// an output stall holds the input register and then stalls the input.
// Reset (rst, synchronous, active high) restores the register defaults and clears the run state.
module threshold_run_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [trd_pkg::REG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [trd_pkg::CFG_WIDTH-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch0,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch1,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch2,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch3,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch4,
  input  logic signed [trd_pkg::SAMPLE_WIDTH-1:0] sample_ch5,
  input  logic [trd_pkg::INDEX_WIDTH-1:0]      sample_index,
  input  logic                                 range_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 run_found,
  output logic [trd_pkg::INDEX_WIDTH-1:0]      run_start_index,
  output logic [trd_pkg::INDEX_WIDTH-1:0]      run_end_index,
  output logic                                 search_done,
  output logic                                 none_found
);
  import trd_pkg::*;

  cfg_t        cfg;
  chan_arr_t   in_chan;
  logic        s1_valid;
  chan_arr_t   s1_chan;
  index_t      s1_index;
  logic        s1_range_end;
  logic        advance;
  logic        s1_fire;
  logic        in_accept;
  logic        hit;
  logic        emit;
  result_t     result;
  trk_status_t trk_status;

  assign in_chan = {sample_ch5, sample_ch4, sample_ch3, sample_ch2, sample_ch1, sample_ch0};

  assign advance   = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  trd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trd_qualify u_qualify (
    .cfg  (cfg),
    .chan (s1_chan),
    .hit  (hit)
  );

  trd_run_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (s1_fire),
    .hit    (hit),
    .idx    (s1_index),
    .last   (s1_range_end),
    .emit   (emit),
    .result (result),
    .status (trk_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_chan      <= in_chan;
      s1_index     <= sample_index;
      s1_range_end <= range_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      run_found       <= result.run_found;
      run_start_index <= result.run_start_index;
      run_end_index   <= result.run_end_index;
      search_done     <= result.search_done;
      none_found      <= result.none_found;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_range_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_range_end |=> !trk_status.in_run && !trk_status.any_reported)
    else $error("run state not cleared after the end of a range");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_found || search_done)
    else $error("result carries neither a run nor the end of a range");

  a_none_found_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> search_done && !run_found)
    else $error("none_found set on a result that is not a plain search end");

endmodule

### hw/rtl/trd_cfg_regs.sv
module trd_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [trd_pkg::REG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [trd_pkg::CFG_WIDTH-1:0]        cfg_data,
  output trd_pkg::cfg_t                        cfg
);
  import trd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.compare_mode     <= MODE_ABOVE;
      cfg.channel_a_select <= SEL_WIDTH'(0);
      cfg.channel_b_select <= SEL_WIDTH'(1);
      cfg.threshold_a_low  <= SAMPLE_WIDTH'(0);
      cfg.threshold_a_high <= SAMPLE_WIDTH'(32767);
      cfg.threshold_b      <= SAMPLE_WIDTH'(0);
      cfg.min_run_length   <= LEN_WIDTH'(1);
      cfg.report_all       <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COMPARE_MODE:     cfg.compare_mode     <= cfg_data[MODE_WIDTH-1:0];
        REG_CHANNEL_A_SELECT: cfg.channel_a_select <= cfg_data[SEL_WIDTH-1:0];
        REG_CHANNEL_B_SELECT: cfg.channel_b_select <= cfg_data[SEL_WIDTH-1:0];
        REG_THRESHOLD_A_LOW:  cfg.threshold_a_low  <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_THRESHOLD_A_HIGH: cfg.threshold_a_high <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_THRESHOLD_B:      cfg.threshold_b      <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_MIN_RUN_LENGTH:   cfg.min_run_length   <= cfg_data[LEN_WIDTH-1:0];
        REG_REPORT_ALL:       cfg.report_all       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/trd_qualify.sv
module trd_qualify (
  input  trd_pkg::cfg_t      cfg,
  input  trd_pkg::chan_arr_t chan,
  output logic               hit
);
  import trd_pkg::*;

  sample_t a_val;
  sample_t b_val;
  logic    a_above;
  logic    a_below;
  logic    b_above;

  function automatic sample_t pick(input chan_arr_t ch, input sel_t sel);
    sample_t v;
    v = '0;
    if ({1'b0, sel} < (SEL_WIDTH + 1)'(NUM_CHANNELS)) begin
      v = ch[sel];
    end
    return v;
  endfunction

  assign a_val   = pick(chan, cfg.channel_a_select);
  assign b_val   = pick(chan, cfg.channel_b_select);
  assign a_above = a_val > cfg.threshold_a_low;
  assign a_below = a_val < cfg.threshold_a_high;
  assign b_above = b_val > cfg.threshold_b;

  always_comb begin
    case (cfg.compare_mode)
      MODE_ABOVE: hit = a_above;
      MODE_BAND:  hit = a_above && a_below;
      MODE_DUAL:  hit = a_above && b_above;
      default:    hit = 1'b0;
    endcase
  end

endmodule

### hw/rtl/trd_run_tracker.sv
module trd_run_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  trd_pkg::cfg_t         cfg,
  input  logic                  step,
  input  logic                  hit,
  input  trd_pkg::index_t       idx,
  input  logic                  last,
  output logic                  emit,
  output trd_pkg::result_t      result,
  output trd_pkg::trk_status_t  status
);
  import trd_pkg::*;

  logic   in_run;
  index_t open_run_start;
  index_t open_run_last;
  len_t   open_run_length;
  logic   any_reported;

  len_t   len_next;
  index_t start_next;
  logic   closed;
  len_t   close_len;
  index_t close_start;
  index_t close_last;
  logic   report;
  logic   any_next;

  always_comb begin
    if (!in_run) begin
      len_next   = LEN_WIDTH'(1);
      start_next = idx;
    end else begin
      len_next   = (open_run_length == '1) ? open_run_length : open_run_length + LEN_WIDTH'(1);
      start_next = open_run_start;
    end
    closed      = hit ? last : in_run;
    close_len   = hit ? len_next : open_run_length;
    close_start = hit ? start_next : open_run_start;
    close_last  = hit ? idx : open_run_last;
    report      = closed && (close_len >= cfg.min_run_length) &&
                  (cfg.report_all || !any_reported);
    any_next    = any_reported || report;
  end

  assign emit                   = report || last;
  assign result.run_found       = report;
  assign result.run_start_index = report ? close_start : '0;
  assign result.run_end_index   = report ? close_last : '0;
  assign result.search_done     = last;
  assign result.none_found      = last && !any_next;
  assign status.in_run          = in_run;
  assign status.any_reported    = any_reported;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run          <= 1'b0;
      open_run_start  <= '0;
      open_run_last   <= '0;
      open_run_length <= '0;
      any_reported    <= 1'b0;
    end else if (step) begin
      if (last) begin
        in_run          <= 1'b0;
        open_run_start  <= '0;
        open_run_last   <= '0;
        open_run_length <= '0;
        any_reported    <= 1'b0;
      end else if (closed) begin
        in_run          <= 1'b0;
        open_run_length <= '0;
        any_reported    <= any_next;
      end else if (hit) begin
        in_run          <= 1'b1;
        open_run_start  <= start_next;
        open_run_last   <= idx;
        open_run_length <= len_next;
      end
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import trd_pkg::*;

  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 620;
  localparam int LONG_RUN = 300;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [REG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  chan_arr_t drive_ch;
  index_t sample_index;
  logic range_end;
  logic out_valid;
  logic out_stall;
  logic run_found;
  index_t run_start_index;
  index_t run_end_index;
  logic search_done;
  logic none_found;

  cfg_t model_cfg;
  logic run_open;
  index_t run_first;
  index_t run_last;
  len_t run_len;
  logic run_reported;
  result_t due_reports[$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit gaps_off = 1'b0;
  int random_fed = 0;

  threshold_run_detector DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_ch0(drive_ch[0]),
    .sample_ch1(drive_ch[1]),
    .sample_ch2(drive_ch[2]),
    .sample_ch3(drive_ch[3]),
    .sample_ch4(drive_ch[4]),
    .sample_ch5(drive_ch[5]),
    .sample_index(sample_index),
    .range_end(range_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .run_found(run_found),
    .run_start_index(run_start_index),
    .run_end_index(run_end_index),
    .search_done(search_done),
    .none_found(none_found)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver switches between free flow, light stalls, heavy stalls and long held stalls.
  initial begin
    int kind;
    int phase_len;
    out_stall = 1'b0;
    forever begin
      kind = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 200);
      repeat (phase_len) begin
        @(negedge clk);
        case (kind)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 2) == 0);
          2: out_stall = ($urandom_range(0, 4) != 0);
          default: out_stall = ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  function automatic void clear_run_state();
    run_open = 1'b0;
    run_first = '0;
    run_last = '0;
    run_len = '0;
    run_reported = 1'b0;
  endfunction

  function automatic void load_register(logic [REG_IDX_WIDTH-1:0] idx,
                                        logic [CFG_WIDTH-1:0] data);
    case (idx)
      REG_COMPARE_MODE: model_cfg.compare_mode = data[MODE_WIDTH-1:0];
      REG_CHANNEL_A_SELECT: model_cfg.channel_a_select = data[SEL_WIDTH-1:0];
      REG_CHANNEL_B_SELECT: model_cfg.channel_b_select = data[SEL_WIDTH-1:0];
      REG_THRESHOLD_A_LOW: model_cfg.threshold_a_low = data[SAMPLE_WIDTH-1:0];
      REG_THRESHOLD_A_HIGH: model_cfg.threshold_a_high = data[SAMPLE_WIDTH-1:0];
      REG_THRESHOLD_B: model_cfg.threshold_b = data[SAMPLE_WIDTH-1:0];
      REG_MIN_RUN_LENGTH: model_cfg.min_run_length = data[LEN_WIDTH-1:0];
      REG_REPORT_ALL: model_cfg.report_all = data[0];
      default: ;
    endcase
  endfunction

  function automatic sample_t channel_of(chan_arr_t ch, sel_t sel);
    if (sel < NUM_CHANNELS) begin
      return ch[sel];
    end
    return '0;
  endfunction

  function automatic bit sample_qualifies(chan_arr_t ch);
    sample_t a;
    sample_t b;
    sample_t lo;
    sample_t hi;
    sample_t thr_b;
    a = channel_of(ch, model_cfg.channel_a_select);
    b = channel_of(ch, model_cfg.channel_b_select);
    lo = model_cfg.threshold_a_low;
    hi = model_cfg.threshold_a_high;
    thr_b = model_cfg.threshold_b;
    case (model_cfg.compare_mode)
      MODE_ABOVE: return a > lo;
      MODE_BAND: return (a > lo) && (a < hi);
      MODE_DUAL: return (a > lo) && (b > thr_b);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void track_sample(chan_arr_t ch, index_t idx, logic last);
    bit closed;
    bit report;
    result_t res;
    closed = 1'b0;
    report = 1'b0;
    res = '0;
    if (sample_qualifies(ch)) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_first = idx;
        run_len = '0;
      end
      run_last = idx;
      if (run_len != '1) begin
        run_len++;
      end
      closed = last;
    end else if (run_open) begin
      closed = 1'b1;
    end
    if (closed) begin
      if (run_len >= model_cfg.min_run_length && (model_cfg.report_all || !run_reported)) begin
        report = 1'b1;
        res.run_found = 1'b1;
        res.run_start_index = run_first;
        res.run_end_index = run_last;
        run_reported = 1'b1;
      end
      run_open = 1'b0;
      run_len = '0;
    end
    if (report || last) begin
      res.search_done = last;
      res.none_found = last && !run_reported;
      due_reports.insert(due_reports.size(), res);
    end
    if (last) begin
      clear_run_state();
    end
  endfunction

  function automatic void check_field(string name, logic [INDEX_WIDTH-1:0] want,
                                      logic [INDEX_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_report();
    result_t want;
    if (due_reports.size() == 0) begin
      $display("%0t: unexpected result, actual found=%0b start=%0d end=%0d done=%0b none=%0b",
               $time, run_found, run_start_index, run_end_index, search_done, none_found);
      mismatch_count++;
    end else begin
      want = due_reports.pop_front();
      check_field("run_found", want.run_found, run_found);
      check_field("run_start_index", want.run_start_index, run_start_index);
      check_field("run_end_index", want.run_end_index, run_end_index);
      check_field("search_done", want.search_done, search_done);
      check_field("none_found", want.none_found, none_found);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      model_cfg = '{compare_mode: MODE_ABOVE, channel_a_select: 3'd0, channel_b_select: 3'd1,
                    threshold_a_low: '0, threshold_a_high: SAMPLE_MAX, threshold_b: '0,
                    min_run_length: 16'd1, report_all: 1'b0};
      clear_run_state();
      due_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_report();
      end
      if (cfg_write) begin
        load_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        track_sample(drive_ch, sample_index, range_end);
      end
    end
  end

  task automatic feed_sample(chan_arr_t ch, index_t idx, logic last);
    if (!gaps_off) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) begin
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
      burst_left--;
    end
    drive_ch = ch;
    sample_index = idx;
    range_end = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic chan_arr_t random_channels();
    chan_arr_t ch;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch[i] = sample_t'($urandom);
    end
    return ch;
  endfunction

  task automatic feed_pair(sample_t a_val, sample_t b_val, index_t idx, logic last);
    chan_arr_t ch;
    ch = random_channels();
    if (model_cfg.channel_a_select < NUM_CHANNELS) begin
      ch[model_cfg.channel_a_select] = a_val;
    end
    if (model_cfg.channel_b_select < NUM_CHANNELS) begin
      ch[model_cfg.channel_b_select] = b_val;
    end
    feed_sample(ch, idx, last);
  endtask

  task automatic wait_drained();
    while (due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_WIDTH-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [CFG_WIDTH-1:0] pad_upper(logic [CFG_WIDTH-1:0] v, int w, bit dirty);
    if (dirty) begin
      return CFG_WIDTH'(($urandom << w) | v);
    end
    return v;
  endfunction

  task automatic apply_settings(logic [MODE_WIDTH-1:0] mode, sel_t a_sel, sel_t b_sel,
                                sample_t lo, sample_t hi, sample_t thr_b, len_t min_len,
                                logic all_runs, bit dirty);
    wait_drained();
    write_reg(REG_COMPARE_MODE, pad_upper(CFG_WIDTH'(mode), MODE_WIDTH, dirty));
    write_reg(REG_CHANNEL_A_SELECT, pad_upper(CFG_WIDTH'(a_sel), SEL_WIDTH, dirty));
    write_reg(REG_CHANNEL_B_SELECT, pad_upper(CFG_WIDTH'(b_sel), SEL_WIDTH, dirty));
    write_reg(REG_THRESHOLD_A_LOW, lo);
    write_reg(REG_THRESHOLD_A_HIGH, hi);
    write_reg(REG_THRESHOLD_B, thr_b);
    write_reg(REG_MIN_RUN_LENGTH, min_len);
    write_reg(REG_REPORT_ALL, pad_upper(CFG_WIDTH'(all_runs), 1, dirty));
  endtask

  task automatic test_reset_defaults();
    feed_pair(16'sd1, '0, 16'd0, 1'b0);
    feed_pair(-16'sd1, '0, 16'd1, 1'b0);
    feed_pair(16'sd5, '0, 16'd2, 1'b0);
    feed_pair(16'sd5, '0, 16'd3, 1'b1);
    feed_pair(16'sd0, '0, 16'hFFFF, 1'b0);
    feed_pair(SAMPLE_MIN, '0, 16'd0, 1'b1);
    feed_pair(SAMPLE_MAX, '0, 16'hFFFF, 1'b1);
  endtask

  task automatic test_compare_modes();
    apply_settings(MODE_BAND, 3'd5, 3'd0, SAMPLE_MIN, SAMPLE_MAX, '0, 16'd1, 1'b1, 1'b0);
    feed_pair(SAMPLE_MIN, '0, 16'd10, 1'b0);
    feed_pair(SAMPLE_MAX, '0, 16'd9, 1'b0);
    feed_pair(16'sd0, '0, 16'd8, 1'b1);
    apply_settings(MODE_BAND, 3'd4, 3'd0, 16'sd6, 16'sd5, '0, 16'd1, 1'b1, 1'b0);
    feed_pair(16'sd5, '0, 16'd20, 1'b0);
    feed_pair(16'sd6, '0, 16'd21, 1'b1);
    apply_settings(MODE_DUAL, 3'd3, 3'd4, -16'sd1, SAMPLE_MAX, 16'sd32766, 16'd1, 1'b1, 1'b0);
    feed_pair(16'sd0, SAMPLE_MAX, 16'd30, 1'b0);
    feed_pair(16'sd0, 16'sd32766, 16'd31, 1'b0);
    feed_pair(-16'sd1, SAMPLE_MAX, 16'd32, 1'b0);
    feed_pair(SAMPLE_MAX, SAMPLE_MAX, 16'd33, 1'b1);
    apply_settings(MODE_UNUSED, 3'd0, 3'd1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 16'd0, 1'b1,
                   1'b0);
    feed_pair(SAMPLE_MAX, SAMPLE_MAX, 16'd40, 1'b1);
  endtask

  task automatic test_select_and_length();
    apply_settings(MODE_ABOVE, 3'd7, 3'd6, -16'sd1, SAMPLE_MAX, '0, 16'd0, 1'b1, 1'b0);
    feed_pair(SAMPLE_MIN, SAMPLE_MIN, 16'd50, 1'b0);
    feed_pair(SAMPLE_MIN, SAMPLE_MIN, 16'd51, 1'b1);
    apply_settings(MODE_DUAL, 3'd6, 3'd0, 16'sd0, SAMPLE_MAX, SAMPLE_MIN, 16'd0, 1'b1, 1'b0);
    feed_pair(SAMPLE_MAX, SAMPLE_MAX, 16'd60, 1'b0);
    feed_pair(SAMPLE_MAX, SAMPLE_MAX, 16'd61, 1'b1);
    apply_settings(MODE_ABOVE, 3'd0, 3'd1, 16'sd0, SAMPLE_MAX, '0, 16'd3, 1'b0, 1'b0);
    feed_pair(16'sd1, '0, 16'd70, 1'b0);
    feed_pair(16'sd1, '0, 16'd71, 1'b0);
    feed_pair(16'sd0, '0, 16'd72, 1'b0);
    feed_pair(16'sd2, '0, 16'd73, 1'b0);
    feed_pair(16'sd2, '0, 16'd74, 1'b0);
    feed_pair(16'sd2, '0, 16'd75, 1'b0);
    feed_pair(-16'sd2, '0, 16'd76, 1'b1);
  endtask

  // A long back-to-back run whose length just meets the minimum must be reported.
  task automatic test_long_run();
    sample_t a;
    index_t idx;
    apply_settings(MODE_ABOVE, 3'd2, 3'd0, SAMPLE_MIN, SAMPLE_MAX, '0, len_t'(LONG_RUN), 1'b1,
                   1'b0);
    gaps_off = 1'b1;
    idx = index_t'($urandom);
    for (int n = 0; n < LONG_RUN; n++) begin
      a = sample_t'($urandom);
      if (a == SAMPLE_MIN) begin
        a = SAMPLE_MAX;
      end
      feed_pair(a, '0, idx, 1'b0);
      idx++;
    end
    feed_pair(SAMPLE_MIN, '0, idx, 1'b0);
    feed_pair(16'sd0, '0, idx + 16'd1, 1'b0);
    feed_pair(16'sd0, '0, idx + 16'd2, 1'b1);
    gaps_off = 1'b0;
  endtask

  function automatic sample_t pick_level();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic sample_t near_level(sample_t level);
    case ($urandom_range(0, 5))
      0: return sample_t'($urandom);
      1: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return level + sample_t'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  function automatic chan_arr_t shaped_channels(bit want);
    chan_arr_t ch;
    sample_t levels[3];
    levels[0] = model_cfg.threshold_a_low;
    levels[1] = model_cfg.threshold_a_high;
    levels[2] = model_cfg.threshold_b;
    for (int tries = 0; tries < 8; tries++) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch[i] = near_level(levels[$urandom_range(0, 2)]);
      end
      if (sample_qualifies(ch) == want) begin
        return ch;
      end
    end
    return ch;
  endfunction

  task automatic randomize_settings();
    logic [MODE_WIDTH-1:0] mode;
    sel_t a_sel;
    sel_t b_sel;
    sample_t lo;
    sample_t hi;
    sample_t swap;
    len_t min_len;
    mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : MODE_WIDTH'($urandom_range(0, 2));
    a_sel = ($urandom_range(0, 9) == 0) ? SEL_WIDTH'($urandom_range(6, 7)) :
                                          SEL_WIDTH'($urandom_range(0, 5));
    b_sel = ($urandom_range(0, 9) == 0) ? SEL_WIDTH'($urandom_range(6, 7)) :
                                          SEL_WIDTH'($urandom_range(0, 5));
    lo = pick_level();
    hi = pick_level();
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    case ($urandom_range(0, 19))
      0: min_len = '1;
      1: min_len = len_t'($urandom);
      2, 3, 4, 5, 6, 7, 8, 9: min_len = len_t'($urandom_range(4, 8));
      default: min_len = len_t'($urandom_range(0, 3));
    endcase
    apply_settings(mode, a_sel, b_sel, lo, hi, pick_level(), min_len,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Noisy ranges carry unrelated indices, fully random samples and early range ends.
  task automatic random_range(bit noisy);
    int len;
    index_t idx;
    bit want;
    bit descending;
    bit last;
    chan_arr_t ch;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    idx = index_t'($urandom);
    descending = 1'($urandom_range(0, 1));
    want = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        want = !want;
      end
      last = (i == len - 1) || (noisy && $urandom_range(0, 9) == 0);
      ch = noisy ? random_channels() : shaped_channels(want);
      feed_sample(ch, noisy ? index_t'($urandom) : idx, last);
      idx = descending ? idx - 16'd1 : idx + 16'd1;
    end
    random_fed += len;
  endtask

  task automatic test_random_ranges();
    while (random_fed < RANDOM_ITEMS) begin
      randomize_settings();
      gaps_off = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        random_range($urandom_range(0, 4) == 0);
      end
      gaps_off = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    drive_ch = '0;
    sample_index = '0;
    range_end = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_compare_modes();
    test_select_and_length();
    test_long_run();
    test_random_ranges();
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
